// File: design/ffd_pkg.sv
`default_nettype none

package ffd_pkg;

  // line geometry: the length is a power of two so pointer math wraps by itself
  localparam int unsigned ADDR_W     = 14;
  localparam int unsigned MAX_LENGTH = 1 << ADDR_W;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned DELAY_W  = FRAC_W + ADDR_W;
  localparam int unsigned GAIN_W   = 16;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_NEXT,
    S_INTERP,
    S_FEEDBACK,
    S_WRITE
  } ffd_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;   // input transfer: latch sample and delay, read the tap
    logic cap_a;     // capture the tap entry, read the entry after it
    logic cap_y;     // capture the interpolated sample
    logic cap_p;     // capture the feedback product
    logic commit;    // write back, advance pointer, load output register
  } ffd_cmd_t;

endpackage

`default_nettype wire

// File: design/fractional_feedback_delay_core.sv
// pacing: the sequencer takes one sample at a time, stepping through read next,
//   interpolate, feedback and write states, an order set by the two reads that share the
//   one ram read port and the two multiply stages; the write waits while the output stalls
// reset: pointer, fill tracking, gain and valid flags clear at once; entries not
//   written since reset read as zero through fill tracking, so no clearing pass
`default_nettype none

module fractional_feedback_delay_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic signed [ffd_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic [ffd_pkg::DELAY_W-1:0]         delay_amount_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [ffd_pkg::SAMPLE_W-1:0] sample_out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic signed [ffd_pkg::GAIN_W-1:0]   cfg_wdata_i
);
  import ffd_pkg::*;

  ffd_cmd_t cmd;

  // sequencer
  ffd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // delay line and arithmetic
  ffd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_in_i    (sample_in_i),
    .delay_amount_i (delay_amount_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_out_o   (sample_out_o)
  );

endmodule

`default_nettype wire

// File: design/ffd_ram.sv
`default_nettype none

module ffd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/ffd_ctrl.sv
`default_nettype none

module ffd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      ffd_pkg::ffd_cmd_t cmd_o
);
  import ffd_pkg::*;

  ffd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_READ_NEXT;
      S_READ_NEXT: state_d = S_INTERP;
      S_INTERP:    state_d = S_FEEDBACK;
      S_FEEDBACK:  state_d = S_WRITE;
      S_WRITE:     if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:      cmd_o.load_in = in_valid_i;
      S_READ_NEXT: cmd_o.cap_a   = 1'b1;
      S_INTERP:    cmd_o.cap_y   = 1'b1;
      S_FEEDBACK:  cmd_o.cap_p   = 1'b1;
      S_WRITE:     cmd_o.commit  = out_free;
      default:     cmd_o = '0;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: design/ffd_datapath.sv
`default_nettype none

module ffd_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ffd_pkg::ffd_cmd_t                   cmd_i,
  input  wire logic signed [ffd_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic [ffd_pkg::DELAY_W-1:0]         delay_amount_i,
  input  wire logic                                cfg_we_i,
  input  wire logic signed [ffd_pkg::GAIN_W-1:0]   cfg_wdata_i,
  output      logic signed [ffd_pkg::SAMPLE_W-1:0] sample_out_o
);
  import ffd_pkg::*;

  localparam int unsigned SUM_W  = SAMPLE_W + FRAC_W + 2;
  localparam int unsigned PROD_W = SAMPLE_W + GAIN_W;
  localparam int unsigned FB_W   = PROD_W + 1 - (GAIN_W - 1);
  localparam int unsigned ACC_W  = FB_W;

  logic signed [SAMPLE_W-1:0] x_q;
  logic [FRAC_W-1:0]          frac_q;
  logic [ADDR_W-1:0]          rd_q;
  logic signed [SAMPLE_W-1:0] a_q;
  logic signed [SAMPLE_W-1:0] y_q;
  logic signed [PROD_W-1:0]   p_q;
  logic signed [GAIN_W-1:0]   gain_q;
  logic [ADDR_W-1:0]          wp_q;
  logic                       wrapped_q;
  logic signed [SAMPLE_W-1:0] out_q;

  logic [ADDR_W-1:0]          rd_in;
  logic [ADDR_W-1:0]          nx;
  logic [ADDR_W-1:0]          raddr;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] a_val;
  logic signed [SAMPLE_W-1:0] b_val;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [FRAC_W:0]     frac_s;
  logic signed [SUM_W-1:0]    interp_sum;
  logic signed [SAMPLE_W-1:0] y_d;
  logic signed [PROD_W-1:0]   p_d;
  logic signed [PROD_W:0]     p_round;
  logic signed [FB_W-1:0]     fb;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] wb_data;

  // entry value as seen after reset: current slot bypasses to the new sample,
  // slots not yet written since reset read as zero
  function automatic logic signed [SAMPLE_W-1:0] entry_value(
    input logic [ADDR_W-1:0]   addr,
    input logic [ADDR_W-1:0]   wp,
    input logic                wrapped,
    input logic [SAMPLE_W-1:0] data,
    input logic [SAMPLE_W-1:0] x
  );
    logic signed [SAMPLE_W-1:0] v;
    if (addr == wp) begin
      v = $signed(x);
    end else if (wrapped || (addr < wp)) begin
      v = $signed(data);
    end else begin
      v = '0;
    end
    return v;
  endfunction

  // read addresses: tap behind the pointer, then the entry after it
  assign rd_in = wp_q - delay_amount_i[FRAC_W +: ADDR_W];
  assign nx    = rd_q + ADDR_W'(1);
  assign raddr = cmd_i.load_in ? rd_in : nx;

  ffd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_LENGTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (wp_q),
    .wdata_i (wb_data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign a_val = entry_value(rd_q, wp_q, wrapped_q, rdata, x_q);
  assign b_val = entry_value(nx, wp_q, wrapped_q, rdata, x_q);

  // linear interpolation, rounded half up
  assign diff       = (SAMPLE_W+1)'(b_val) - (SAMPLE_W+1)'(a_q);
  assign frac_s     = $signed({1'b0, frac_q});
  assign interp_sum = ($signed({{2{a_q[SAMPLE_W-1]}}, a_q, {FRAC_W{1'b0}}}))
                    + (SUM_W'(diff) * SUM_W'(frac_s))
                    + SUM_W'(1 << (FRAC_W - 1));
  assign y_d        = interp_sum[FRAC_W +: SAMPLE_W];

  // feedback product
  assign p_d = PROD_W'(y_q) * PROD_W'(gain_q);

  // q1.15 rounding, add to input, saturate
  assign p_round = (PROD_W+1)'(p_q) + (PROD_W+1)'(1 << (GAIN_W - 2));
  assign fb      = p_round[PROD_W:GAIN_W-1];
  assign acc     = ACC_W'(x_q) + fb;

  always_comb begin
    if (acc > ACC_W'((1 << (SAMPLE_W - 1)) - 1)) begin
      wb_data = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (acc < -ACC_W'(1 << (SAMPLE_W - 1))) begin
      wb_data = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      wb_data = acc[SAMPLE_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q    <= sample_in_i;
      frac_q <= delay_amount_i[FRAC_W-1:0];
      rd_q   <= rd_in;
    end
    if (cmd_i.cap_a) begin
      a_q <= a_val;
    end
    if (cmd_i.cap_y) begin
      y_q <= y_d;
    end
    if (cmd_i.cap_p) begin
      p_q <= p_d;
    end
    if (cmd_i.commit) begin
      out_q <= y_q;
    end
  end

  // pointer, fill tracking and gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      gain_q    <= '0;
    end else begin
      if (cmd_i.commit) begin
        wp_q <= wp_q + ADDR_W'(1);
        if (wp_q == ADDR_W'(MAX_LENGTH - 1)) begin
          wrapped_q <= 1'b1;
        end
      end
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
    end
  end

  assign sample_out_o = out_q;

endmodule

`default_nettype wire

// File: design/ffd_checker.sv
`default_nettype none

module ffd_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [ffd_pkg::SAMPLE_W-1:0] sample_out_o
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("result dropped or changed while stalled");

  // one sample at a time: no new input right after a transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a sample is in flight");

  // a fresh result shows up exactly after the pipeline latency
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 5))
    else $error("result appeared without a matching input transfer");

  // input ready is still low in the write state after an input transfer
  a_busy_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##4 !in_ready_o)
    else $error("input ready returned too early");

endmodule

bind fractional_feedback_delay_core ffd_checker u_ffd_checker (.*);

`default_nettype wire
